// File: hdl/mpfe_pkg.sv
// Shared types and constants for the Manchester PWM frame encoder.
package mpfe_pkg;

  localparam int LEVEL_W     = 16;
  localparam int SEG_W       = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_IDX_W   = 2;

  localparam logic [SEG_W-1:0] SEG_IDLE    = 2'd0;
  localparam logic [SEG_W-1:0] SEG_HEADER  = 2'd1;
  localparam logic [SEG_W-1:0] SEG_DATA    = 2'd2;
  localparam logic [SEG_W-1:0] SEG_TRAILER = 2'd3;

  localparam logic OP_IDLE = 1'b0;
  localparam logic OP_BYTE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LEVEL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_LEVEL = 2'd2;

  localparam logic [LEVEL_W-1:0] HIGH_LEVEL_RESET = 16'd250;
  localparam logic [LEVEL_W-1:0] LOW_LEVEL_RESET  = 16'd5;
  localparam logic [LEVEL_W-1:0] FULL_LEVEL_RESET = 16'd255;

  // classified command handed from front to back
  typedef struct packed {
    logic [SEG_W-1:0] start_seg;
    logic [7:0]       data;
    logic             trailer;
  } cmd_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] high_level;
    logic [LEVEL_W-1:0] low_level;
    logic [LEVEL_W-1:0] full_level;
  } levels_t;

endpackage

// File: hdl/manchester_pwm_frame_encoder.sv
// An accepted word is queued; its first value is registered when the back end pops it.
// One value per cycle while out_ready is high: a byte gives 16, plus SYNC_VALUES each
// for header (first_byte) and trailer (last_byte); an idle word gives IDLE_VALUES.
// A two-entry queue lets new words be taken while the sequencer works.
// Reset (rst, synchronous) empties the queue and output and loads levels 250, 5, 255.
module manchester_pwm_frame_encoder
  import mpfe_pkg::*;
#(
  parameter int SYNC_VALUES = 8,
  parameter int IDLE_VALUES = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEVEL_W-1:0]   cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 op,
  input  logic [7:0]           data_byte,
  input  logic                 first_byte,
  input  logic                 last_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [LEVEL_W-1:0]   duty,
  output logic [SEG_W-1:0]     segment,
  output logic                 run_end
);

  levels_t levels;
  logic    q_push;
  logic    q_pop;
  logic    q_valid;
  logic    q_full;
  cmd_t    q_cmd;
  cmd_t    q_head;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      levels.high_level <= HIGH_LEVEL_RESET;
      levels.low_level  <= LOW_LEVEL_RESET;
      levels.full_level <= FULL_LEVEL_RESET;
    end else if (cfg_en) begin
      case (cfg_index)
        REG_HIGH_LEVEL: levels.high_level <= cfg_data;
        REG_LOW_LEVEL:  levels.low_level  <= cfg_data;
        REG_FULL_LEVEL: levels.full_level <= cfg_data;
        default:        levels            <= levels;
      endcase
    end
  end

  mpfe_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .data_byte  (data_byte),
    .first_byte (first_byte),
    .last_byte  (last_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_cmd)
  );

  mpfe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .head     (q_head),
    .count    (q_count)
  );

  mpfe_back #(
    .SYNC_VALUES (SYNC_VALUES),
    .IDLE_VALUES (IDLE_VALUES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .levels    (levels),
    .q_valid   (q_valid),
    .head      (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .duty      (duty),
    .segment   (segment),
    .run_end   (run_end)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= ($bits(q_count))'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

  a_header_no_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && segment == SEG_HEADER |-> !run_end)
    else $error("word ended inside header");

  a_header_then_header_or_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && segment == SEG_HEADER |=>
      !out_valid || segment == SEG_HEADER || segment == SEG_DATA)
    else $error("header not followed by header or data");

endmodule

// File: hdl/mpfe_front.sv
// Front end: accepts input words and classifies them into commands.
module mpfe_front
  import mpfe_pkg::*;
(
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       op,
  input  logic [7:0] data_byte,
  input  logic       first_byte,
  input  logic       last_byte,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd = '0;
    unique case (op)
      OP_IDLE: begin
        q_cmd.start_seg = SEG_IDLE;
      end
      OP_BYTE: begin
        q_cmd.start_seg = first_byte ? SEG_HEADER : SEG_DATA;
        q_cmd.data      = data_byte;
        q_cmd.trailer   = last_byte;
      end
      default: q_cmd = '0;
    endcase
  end

endmodule

// File: hdl/mpfe_queue.sv
// Short command queue between front and back.
module mpfe_queue
  import mpfe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic q_valid,
  output logic q_full,
  output cmd_t head,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

  cmd_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  assign q_valid = count != '0;
  assign q_full  = count == CNT_W'(QUEUE_DEPTH);
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hdl/mpfe_back.sv
// Back end: steps through header, data, trailer or idle values of one command.
module mpfe_back
  import mpfe_pkg::*;
#(
  parameter int SYNC_VALUES = 8,
  parameter int IDLE_VALUES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  levels_t            levels,
  input  logic               q_valid,
  input  cmd_t               head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [LEVEL_W-1:0] duty,
  output logic [SEG_W-1:0]   segment,
  output logic               run_end
);

  localparam int MAX_LEN = (SYNC_VALUES > IDLE_VALUES) ?
                           ((SYNC_VALUES > 16) ? SYNC_VALUES : 16) :
                           ((IDLE_VALUES > 16) ? IDLE_VALUES : 16);
  localparam int CNT_W   = $clog2(MAX_LEN);

  logic             busy;
  cmd_t             cmd;
  logic [SEG_W-1:0] seg;
  logic [CNT_W-1:0] cnt;

  cmd_t             cur_cmd;
  logic [SEG_W-1:0] cur_seg;
  logic [CNT_W-1:0] cur_cnt;
  logic             load;
  logic             emit;
  logic             bit_val;
  logic             done;
  logic [LEVEL_W-1:0] val;
  logic [SEG_W-1:0] seg_next;
  logic [CNT_W-1:0] cnt_next;

  // when idle, the next value comes straight from the queue head
  assign cur_cmd = busy ? cmd : head;
  assign cur_seg = busy ? seg : head.start_seg;
  assign cur_cnt = busy ? cnt : '0;

  assign load = !out_valid || out_ready;
  assign emit = load && (busy || q_valid);
  assign pop  = emit && !busy;

  assign bit_val = cur_cmd.data[cur_cnt[3:1]];

  always_comb begin
    val      = levels.low_level;
    done     = 1'b0;
    seg_next = cur_seg;
    cnt_next = cur_cnt + 1'b1;
    unique case (cur_seg)
      SEG_IDLE: begin
        val  = cur_cnt[0] ? levels.low_level : levels.high_level;
        done = cur_cnt == CNT_W'(IDLE_VALUES-1);
      end
      SEG_HEADER: begin
        val = cur_cnt[0] ? levels.high_level : levels.low_level;
        if (cur_cnt == CNT_W'(SYNC_VALUES-1)) begin
          seg_next = SEG_DATA;
          cnt_next = '0;
        end
      end
      SEG_DATA: begin
        // one bit: (low, full); zero bit: (full, low)
        val = (cur_cnt[0] ^ bit_val) ? levels.low_level : levels.full_level;
        if (cur_cnt == CNT_W'(15)) begin
          if (cur_cmd.trailer) begin
            seg_next = SEG_TRAILER;
            cnt_next = '0;
          end else begin
            done = 1'b1;
          end
        end
      end
      SEG_TRAILER: begin
        val  = cur_cnt[0] ? levels.high_level : levels.low_level;
        done = cur_cnt == CNT_W'(SYNC_VALUES-1);
      end
      default: val = levels.low_level;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        busy      <= !done;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      cmd     <= cur_cmd;
      seg     <= seg_next;
      cnt     <= cnt_next;
      duty    <= val;
      segment <= cur_seg;
      run_end <= done;
    end
  end

endmodule
